// File: rtl/mlsfc_pkg.sv
// Shared types and constants for the multi-link state feedback controller.
// Used by the register file, the controller, the datapath and the top level.
package mlsfc_pkg;

  // Fixed field widths.
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned LIMIT_W = 31;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned DRIVE_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MAX_LINKS = 4;

  // Multiplier operands and accumulator.
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = 54;
  localparam int unsigned GAIN_FRAC = 16;
  localparam int unsigned DROP_BITS = 24;

  // Term select: wide enough for the largest link count.
  localparam int unsigned SEL_W = 4;
  localparam logic [SEL_W-1:0] SEL_STEP = 4'd0;
  localparam logic [SEL_W-1:0] SEL_POS  = 4'd1;
  localparam logic [SEL_W-1:0] SEL_VEL  = 4'd2;
  localparam logic [SEL_W-1:0] SEL_LINK = 4'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITION_GAIN    = 3'd0,
    REG_VELOCITY_GAIN    = 3'd1,
    REG_INTEGRAL_GAIN    = 3'd2,
    REG_STEP_TIME        = 3'd3,
    REG_INTEG_CLAMP      = 3'd4,
    REG_LINK_ANGLE_GAINS = 3'd5,
    REG_LINK_RATE_GAINS  = 3'd6,
    REG_LINK_REFERENCES  = 3'd7
  } cfg_reg_e;

  // Configuration register contents.
  typedef struct packed {
    logic signed [DATA_W-1:0] position_gain;
    logic signed [DATA_W-1:0] velocity_gain;
    logic signed [DATA_W-1:0] integral_gain;
    logic [DATA_W-1:0]        step_time;
    logic [LIMIT_W-1:0]       integ_clamp;
    logic [CFG_DATA_W-1:0]    link_angle_gains;
    logic [CFG_DATA_W-1:0]    link_rate_gains;
    logic [CFG_DATA_W-1:0]    link_references;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             clear_int;
    logic             mul_en;
    logic [SEL_W-1:0] sel;
    logic             upd_int;
    logic             acc_clr;
    logic             acc_en;
    logic             out_load;
  } cmd_t;

endpackage

// File: rtl/mlsfc_regs.sv
// Configuration register file of the multi-link state feedback controller.
// Depends on mlsfc_pkg for the register index codes and the cfg_t layout.
module mlsfc_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [mlsfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mlsfc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mlsfc_pkg::cfg_t                    cfg_o
);
  import mlsfc_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register; all registers reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_POSITION_GAIN:    cfg_q.position_gain    <= cfg_data_i[DATA_W-1:0];
        REG_VELOCITY_GAIN:    cfg_q.velocity_gain    <= cfg_data_i[DATA_W-1:0];
        REG_INTEGRAL_GAIN:    cfg_q.integral_gain    <= cfg_data_i[DATA_W-1:0];
        REG_STEP_TIME:        cfg_q.step_time        <= cfg_data_i[DATA_W-1:0];
        REG_INTEG_CLAMP:      cfg_q.integ_clamp      <= cfg_data_i[LIMIT_W-1:0];
        REG_LINK_ANGLE_GAINS: cfg_q.link_angle_gains <= cfg_data_i;
        REG_LINK_RATE_GAINS:  cfg_q.link_rate_gains  <= cfg_data_i;
        REG_LINK_REFERENCES:  cfg_q.link_references  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/mlsfc_ctrl.sv
// Sequencing controller of the multi-link state feedback controller.
// Depends on mlsfc_pkg for the command struct and the term select codes.
module mlsfc_ctrl #(
  parameter int unsigned LINKS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mlsfc_pkg::cmd_t  cmd_o
);
  import mlsfc_pkg::*;

  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(3 + 2 * LINKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INT_MUL,
    S_INT_UPD,
    S_MAC,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [SEL_W-1:0] idx_q;
  logic             out_valid_q;
  cmd_t             cmd;

  // Command decode from the current state and term index.
  always_comb begin
    cmd = '0;
    cmd.sel = idx_q;
    unique case (state_q)
      S_IDLE: begin
        cmd.load      = in_valid_i;
        cmd.clear_int = in_valid_i & mode_i;
      end
      S_INT_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.sel    = SEL_STEP;
      end
      S_INT_UPD: begin
        cmd.upd_int = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_MAC: begin
        cmd.mul_en = 1'b1;
        // The product of the previous cycle is a feedback term after the first issue.
        cmd.acc_en = (idx_q != SEL_POS);
      end
      S_DRAIN: begin
        cmd.acc_en = 1'b1;
      end
      S_DONE: begin
        cmd.out_load = ~out_valid_q | out_ready_i;
      end
      default: ;
    endcase
  end

  // State, term index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= SEL_POS;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !mode_i) begin
            state_q <= S_INT_MUL;
          end
        end
        S_INT_MUL: state_q <= S_INT_UPD;
        S_INT_UPD: begin
          state_q <= S_MAC;
          idx_q   <= SEL_POS;
        end
        S_MAC: begin
          if (idx_q == SEL_LAST) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DRAIN: state_q <= S_DONE;
        S_DONE: begin
          if (cmd.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: rtl/mlsfc_datapath.sv
// Datapath of the multi-link state feedback controller: operand select, one
// shared multiplier, integral clamp, accumulator and output saturation.
// Depends on mlsfc_pkg for widths, select codes, cfg_t and cmd_t.
module mlsfc_datapath #(
  parameter int unsigned LINKS = 4
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  mlsfc_pkg::cfg_t                                   cfg_i,
  input  mlsfc_pkg::cmd_t                                   cmd_i,
  input  logic signed [mlsfc_pkg::DATA_W-1:0]               cart_position_i,
  input  logic signed [mlsfc_pkg::DATA_W-1:0]               cart_velocity_i,
  input  logic [mlsfc_pkg::MAX_LINKS-1:0][mlsfc_pkg::DATA_W-1:0] link_angle_i,
  input  logic [mlsfc_pkg::MAX_LINKS-1:0][mlsfc_pkg::DATA_W-1:0] link_rate_i,
  output logic signed [mlsfc_pkg::DRIVE_W-1:0]              drive_o,
  output logic signed [mlsfc_pkg::INTEG_W-1:0]              integral_value_o,
  output logic                                              drive_saturated_o
);
  import mlsfc_pkg::*;

  localparam logic [SEL_W-1:0] SEL_INTEG = SEL_W'(3 + 2 * LINKS);
  localparam int unsigned SUM_W = INTEG_W + 2;

  logic signed [DATA_W-1:0]               pos_q, vel_q;
  logic [MAX_LINKS-1:0][DATA_W-1:0]       angle_q, rate_q;
  logic signed [INTEG_W-1:0]              integ_q;
  logic signed [PROD_W-1:0]               prod_q;
  logic                                   prod_unscaled_q;
  logic signed [ACC_W-1:0]                acc_q;
  logic signed [DRIVE_W-1:0]              drive_q;
  logic signed [INTEG_W-1:0]              integ_out_q;
  logic                                   sat_q;

  logic signed [MUL_A_W-1:0]              a_op;
  logic signed [MUL_B_W-1:0]              b_op;
  logic signed [DATA_W-1:0]               err;
  logic signed [SUM_W-1:0]                sum, lim_pos, lim_neg;
  logic signed [INTEG_W-1:0]              integ_d;
  logic signed [ACC_W-1:0]                prod_ext, acc_term;
  logic signed [ACC_W-1:0]                neg_acc, quot;
  logic                                   sat_hi, sat_lo;
  logic signed [DRIVE_W-1:0]              drive_d;

  // Operand select for the shared multiplier.
  always_comb begin
    a_op = '0;
    b_op = '0;
    err  = '0;
    if (cmd_i.sel == SEL_STEP) begin
      a_op = MUL_A_W'(pos_q);
      b_op = $signed({1'b0, cfg_i.step_time});
    end else if (cmd_i.sel == SEL_POS) begin
      a_op = MUL_A_W'(pos_q);
      b_op = MUL_B_W'(cfg_i.position_gain);
    end else if (cmd_i.sel == SEL_VEL) begin
      a_op = MUL_A_W'(vel_q);
      b_op = MUL_B_W'(cfg_i.velocity_gain);
    end else if (cmd_i.sel == SEL_INTEG) begin
      a_op = MUL_A_W'(integ_q);
      b_op = MUL_B_W'(cfg_i.integral_gain);
    end
    for (int i = 0; i < LINKS; i++) begin
      // Angle error wraps modulo one turn and reads as a signed half turn.
      if (cmd_i.sel == SEL_W'(3 + i)) begin
        err  = $signed(angle_q[i] - cfg_i.link_references[DATA_W*i +: DATA_W]);
        a_op = MUL_A_W'(err);
        b_op = MUL_B_W'($signed(cfg_i.link_angle_gains[DATA_W*i +: DATA_W]));
      end
      if (cmd_i.sel == SEL_W'(3 + LINKS + i)) begin
        a_op = MUL_A_W'($signed(rate_q[i]));
        b_op = MUL_B_W'($signed(cfg_i.link_rate_gains[DATA_W*i +: DATA_W]));
      end
    end
  end

  // Integral update with a symmetric clamp.
  always_comb begin
    sum     = SUM_W'(integ_q) + $signed(prod_q[SUM_W-1:0]);
    lim_pos = $signed({3'b000, cfg_i.integ_clamp});
    lim_neg = -lim_pos;
    if (sum > lim_pos) begin
      integ_d = lim_pos[INTEG_W-1:0];
    end else if (sum < lim_neg) begin
      integ_d = lim_neg[INTEG_W-1:0];
    end else begin
      integ_d = sum[INTEG_W-1:0];
    end
  end

  // Feedback terms carry the gain fraction scaled up; the integral term does not.
  assign prod_ext = ACC_W'(prod_q);
  assign acc_term = prod_unscaled_q ? prod_ext : (prod_ext <<< GAIN_FRAC);

  // Negate, floor-divide by the fraction and saturate to the drive width.
  always_comb begin
    neg_acc = -acc_q;
    quot    = neg_acc >>> DROP_BITS;
    sat_hi  = !quot[ACC_W-1] && (|quot[ACC_W-2:DRIVE_W-1]);
    sat_lo  = quot[ACC_W-1] && !(&quot[ACC_W-2:DRIVE_W-1]);
    if (sat_hi) begin
      drive_d = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (sat_lo) begin
      drive_d = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_d = quot[DRIVE_W-1:0];
    end
  end

  // Position integral state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (cmd_i.clear_int) begin
      integ_q <= '0;
    end else if (cmd_i.upd_int) begin
      integ_q <= integ_d;
    end
  end

  // Captured word, product, accumulator and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q   <= cart_position_i;
      vel_q   <= cart_velocity_i;
      angle_q <= link_angle_i;
      rate_q  <= link_rate_i;
    end
    if (cmd_i.mul_en) begin
      prod_q          <= a_op * b_op;
      prod_unscaled_q <= (cmd_i.sel == SEL_INTEG);
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + acc_term;
    end
    if (cmd_i.out_load) begin
      drive_q     <= drive_d;
      integ_out_q <= integ_q;
      sat_q       <= sat_hi | sat_lo;
    end
  end

  assign drive_o           = drive_q;
  assign integral_value_o  = integ_out_q;
  assign drive_saturated_o = sat_q;

endmodule

// File: rtl/multi_link_state_feedback_control.sv
// Multi-link full-state feedback controller with a clamped position integral.
//
// Usage: input words arrive on the in_valid_i / in_ready_o channel and carry a
// mode bit, cart position and velocity, and an angle and rate per link. A word
// with mode set clears the position integral and produces no result. A control
// word updates the integral, clamps it to the configured limit and returns the
// negated, gain-weighted state sum as drive_o, saturated to 32 bits.
// Results leave on out_valid_o / out_ready_i. Registers are written over the
// cfg_valid_i channel, which is always ready; write them only while idle.
// Sequence: a control word is accepted in the idle state, the integral step
// is multiplied and the integral updated, the feedback and integral terms
// go through the single shared multiplier, one product per cycle, the last
// product is drained and the result registered, and the next word is taken
// in the following cycle. If the receiver stalls, a finished result
// waits in the output register while the next word is accepted and worked on;
// that word then holds in its last step until the output register frees up.
// Reset clears the configuration registers, the integral and the output valid.
// Depends on mlsfc_pkg, mlsfc_regs, mlsfc_ctrl and mlsfc_datapath.
module multi_link_state_feedback_control #(
  parameter int unsigned LINKS = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    mode_i,
  input  logic signed [mlsfc_pkg::DATA_W-1:0]     cart_position_i,
  input  logic signed [mlsfc_pkg::DATA_W-1:0]     cart_velocity_i,
  input  logic [mlsfc_pkg::DATA_W-1:0]            link_angle_0_i,
  input  logic [mlsfc_pkg::DATA_W-1:0]            link_angle_1_i,
  input  logic [mlsfc_pkg::DATA_W-1:0]            link_angle_2_i,
  input  logic [mlsfc_pkg::DATA_W-1:0]            link_angle_3_i,
  input  logic signed [mlsfc_pkg::DATA_W-1:0]     link_rate_0_i,
  input  logic signed [mlsfc_pkg::DATA_W-1:0]     link_rate_1_i,
  input  logic signed [mlsfc_pkg::DATA_W-1:0]     link_rate_2_i,
  input  logic signed [mlsfc_pkg::DATA_W-1:0]     link_rate_3_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [mlsfc_pkg::DRIVE_W-1:0]    drive_o,
  output logic signed [mlsfc_pkg::INTEG_W-1:0]    integral_value_o,
  output logic                                    drive_saturated_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [mlsfc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mlsfc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import mlsfc_pkg::*;

  cfg_t                             cfg;
  cmd_t                             cmd;
  logic [MAX_LINKS-1:0][DATA_W-1:0] link_angle;
  logic [MAX_LINKS-1:0][DATA_W-1:0] link_rate;

  // Gather the per-link fields into lanes.
  assign link_angle = {link_angle_3_i, link_angle_2_i, link_angle_1_i, link_angle_0_i};
  assign link_rate  = {link_rate_3_i, link_rate_2_i, link_rate_1_i, link_rate_0_i};

  // Register writes are taken every cycle.
  assign cfg_ready_o = 1'b1;

  mlsfc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mlsfc_ctrl #(
    .LINKS (LINKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mlsfc_datapath #(
    .LINKS (LINKS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .cart_position_i   (cart_position_i),
    .cart_velocity_i   (cart_velocity_i),
    .link_angle_i      (link_angle),
    .link_rate_i       (link_rate),
    .drive_o           (drive_o),
    .integral_value_o  (integral_value_o),
    .drive_saturated_o (drive_saturated_o)
  );

endmodule
